// File: rtl/wtfa_pkg.sv
// wtfa_pkg: shared types and sizes for the winograd f(2x3) tile accumulator.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package wtfa_pkg;

   localparam int unsigned TileElems  = 16;
   localparam int unsigned XformWidth = 16;
   localparam int unsigned AccWidth   = 32;
   localparam int unsigned OutElems   = 4;

   typedef logic signed [XformWidth-1:0] xelem_type;
   typedef logic signed [AccWidth-1:0]   acc_type;
   typedef xelem_type                    xtile_type [TileElems];
   typedef acc_type                      acc_tile_type [TileElems];

   // strobes from the top-level flow control into each mac lane
   typedef struct packed {
      logic prod_load;   // word moves from transform stage into product stage
      logic acc_load;    // word leaves product stage and is summed
      logic acc_clear;   // leaving word is the last channel
   } lane_ctl_type;

endpackage

// File: rtl/wtfa_in_xform.sv
// wtfa_in_xform: input transform v = B^T d B on a 4x4 int8 tile, 16-bit wrapping.
// Depends on wtfa_pkg.
`timescale 1ns / 1ps

module wtfa_in_xform (
   input  logic [63:0]         tile_top,
   input  logic [63:0]         tile_bottom,
   output wtfa_pkg::xtile_type v_tile
);

   wtfa_pkg::xelem_type d [4][4];
   wtfa_pkg::xelem_type t [4][4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (r < 2) begin
               d[r][c] = wtfa_pkg::xelem_type'($signed(tile_top[8*(4*r+c) +: 8]));
            end else begin
               d[r][c] = wtfa_pkg::xelem_type'($signed(tile_bottom[8*(4*(r-2)+c) +: 8]));
            end
         end
      end
      for (int c = 0; c < 4; c++) begin
         t[0][c] = d[0][c] - d[2][c];
         t[1][c] = d[1][c] + d[2][c];
         t[2][c] = d[2][c] - d[1][c];
         t[3][c] = d[1][c] - d[3][c];
      end
      for (int r = 0; r < 4; r++) begin
         v_tile[4*r+0] = t[r][0] - t[r][2];
         v_tile[4*r+1] = t[r][1] + t[r][2];
         v_tile[4*r+2] = t[r][2] - t[r][1];
         v_tile[4*r+3] = t[r][1] - t[r][3];
      end
   end

endmodule

// File: rtl/wtfa_mac_lane.sv
// wtfa_mac_lane: one element lane, registered 16x16 product and a wrapping 32-bit accumulator.
// Depends on wtfa_pkg.
`timescale 1ns / 1ps

module wtfa_mac_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  wtfa_pkg::lane_ctl_type  ctl,
   input  wtfa_pkg::xelem_type     v_elem,
   input  logic signed [15:0]      weight,
   output wtfa_pkg::acc_type       sum
);

   wtfa_pkg::acc_type prod_ff;
   wtfa_pkg::acc_type acc_ff;
   wtfa_pkg::acc_type acc_in;

   always_ff @(posedge clock) begin
      if (ctl.prod_load) begin
         prod_ff <= wtfa_pkg::acc_type'(v_elem) * wtfa_pkg::acc_type'(weight);
      end
   end

   assign sum = acc_ff + prod_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_load) begin
         acc_in = ctl.acc_clear ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

// File: rtl/wtfa_out_xform.sv
// wtfa_out_xform: merges the 16 lane sums through y = A^T M A over two stages
// and holds the result word for the rsp channel. Depends on wtfa_pkg.
`timescale 1ns / 1ps

module wtfa_out_xform (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       m_valid,
   output logic                       m_ready,
   input  wtfa_pkg::acc_tile_type     m_tile,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [31:0]         rsp_out_r0_c0,
   output logic signed [31:0]         rsp_out_r0_c1,
   output logic signed [31:0]         rsp_out_r1_c0,
   output logic signed [31:0]         rsp_out_r1_c1
);

   wtfa_pkg::acc_tile_type m_ff;
   wtfa_pkg::acc_type      s_ff [2][4];
   wtfa_pkg::acc_type      s_in [2][4];
   wtfa_pkg::acc_type      y_ff [wtfa_pkg::OutElems];
   wtfa_pkg::acc_type      y_in [wtfa_pkg::OutElems];
   logic                   mv_ff, sv_ff, yv_ff;
   logic                   mv_in, sv_in, yv_in;
   logic                   m_rdy, s_rdy, y_rdy;

   assign y_rdy   = !yv_ff || rsp_ready;
   assign s_rdy   = !sv_ff || y_rdy;
   assign m_rdy   = !mv_ff || s_rdy;
   assign m_ready = m_rdy;

   always_comb begin
      mv_in = m_rdy ? m_valid : mv_ff;
      sv_in = s_rdy ? mv_ff : sv_ff;
      yv_in = y_rdy ? sv_ff : yv_ff;
   end

   // column pass then row pass
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         s_in[0][c] = m_ff[c] + m_ff[4+c] + m_ff[8+c];
         s_in[1][c] = m_ff[4+c] - m_ff[8+c] - m_ff[12+c];
      end
      for (int r = 0; r < 2; r++) begin
         y_in[2*r+0] = s_ff[r][0] + s_ff[r][1] + s_ff[r][2];
         y_in[2*r+1] = s_ff[r][1] - s_ff[r][2] - s_ff[r][3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         sv_ff <= 1'b0;
         yv_ff <= 1'b0;
      end else begin
         mv_ff <= mv_in;
         sv_ff <= sv_in;
         yv_ff <= yv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_rdy && m_valid) begin
         m_ff <= m_tile;
      end
      if (s_rdy && mv_ff) begin
         s_ff <= s_in;
      end
      if (y_rdy && sv_ff) begin
         y_ff <= y_in;
      end
   end

   assign rsp_valid     = yv_ff;
   assign rsp_out_r0_c0 = y_ff[0];
   assign rsp_out_r0_c1 = y_ff[1];
   assign rsp_out_r1_c0 = y_ff[2];
   assign rsp_out_r1_c1 = y_ff[3];

endmodule

// File: rtl/winograd_f23_tile_accumulator.sv
// winograd_f23_tile_accumulator: top level, winograd f(2x3) channel accumulation.
// Depends on wtfa_pkg, wtfa_in_xform, wtfa_mac_lane and wtfa_out_xform.
//
// Usage: the req channel takes one word per input channel: a 4x4 int8 tile and the
// 16 pre-transformed int16 weights of one output channel, plus last_channel. The
// tile is transformed (B^T d B), multiplied lane by lane with the weights and added
// into 16 wrapping 32-bit accumulators. On a word with last_channel set the sums,
// including that word, go through A^T M A and one rsp word carries the 2x2 result
// (four times the true output); the accumulators restart from zero with the next word.
// Throughput: one req word per cycle while req_ready is high, set by the 16 parallel mac lanes.
// After the last word is accepted, the rsp word is built through the transform stage, product
// stage, sum capture, column pass and row pass registers, in that order.
// Reset (synchronous, active high) empties the pipeline and zeroes the accumulators.
// When rsp_ready is low the result word holds; up to three result words queue in the
// merge stages, and only then does req_ready drop. Words without last_channel keep
// flowing as long as no result word is blocked at the lane outputs.
`timescale 1ns / 1ps

module winograd_f23_tile_accumulator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_tile_rows_top,
   input  logic [63:0]        req_tile_rows_bottom,
   input  logic [63:0]        req_weights_row0,
   input  logic [63:0]        req_weights_row1,
   input  logic [63:0]        req_weights_row2,
   input  logic [63:0]        req_weights_row3,
   input  logic               req_last_channel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_r0_c0,
   output logic signed [31:0] rsp_out_r0_c1,
   output logic signed [31:0] rsp_out_r1_c0,
   output logic signed [31:0] rsp_out_r1_c1
);

   wtfa_pkg::xtile_type    v_comb;
   wtfa_pkg::xtile_type    v_ff;
   logic [255:0]           w_ff;
   logic                   x_valid_ff, x_last_ff;
   logic                   x_valid_in;
   logic                   p_valid_ff, p_last_ff;
   logic                   p_valid_in;
   logic                   x_rdy, p_rdy, p_leave;
   logic                   m_ready;
   wtfa_pkg::lane_ctl_type lane_ctl;
   wtfa_pkg::acc_tile_type lane_sum;

   wtfa_in_xform u_in_xform (
      .tile_top    (req_tile_rows_top),
      .tile_bottom (req_tile_rows_bottom),
      .v_tile      (v_comb)
   );

   // product stage leaves freely unless it carries a last word and the merge is full
   assign p_leave   = p_valid_ff && (!p_last_ff || m_ready);
   assign p_rdy     = !p_valid_ff || p_leave;
   assign x_rdy     = !x_valid_ff || p_rdy;
   assign req_ready = x_rdy;

   always_comb begin
      x_valid_in = x_rdy ? req_valid : x_valid_ff;
      p_valid_in = p_rdy ? x_valid_ff : p_valid_ff;
      lane_ctl.prod_load = p_rdy && x_valid_ff;
      lane_ctl.acc_load  = p_leave;
      lane_ctl.acc_clear = p_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_rdy && req_valid) begin
         v_ff      <= v_comb;
         w_ff      <= {req_weights_row3, req_weights_row2, req_weights_row1, req_weights_row0};
         x_last_ff <= req_last_channel;
      end
      if (p_rdy && x_valid_ff) begin
         p_last_ff <= x_last_ff;
      end
   end

   for (genvar i = 0; i < wtfa_pkg::TileElems; i++) begin : g_lane
      wtfa_mac_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .v_elem (v_ff[i]),
         .weight ($signed(w_ff[16*i +: 16])),
         .sum    (lane_sum[i])
      );
   end

   wtfa_out_xform u_out_xform (
      .clock         (clock),
      .reset         (reset),
      .m_valid       (p_valid_ff && p_last_ff),
      .m_ready       (m_ready),
      .m_tile        (lane_sum),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_r0_c0 (rsp_out_r0_c0),
      .rsp_out_r0_c1 (rsp_out_r0_c1),
      .rsp_out_r1_c0 (rsp_out_r1_c0),
      .rsp_out_r1_c1 (rsp_out_r1_c1)
   );

endmodule
